### sv/sdci_pkg.sv
// Shared types, constants and the CRC7 step function for the SD SPI command issuer.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package sdci_pkg;

  // One accepted input beat.
  typedef struct packed {
    logic        func;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       done_res;
    logic [7:0] response;
    logic       timed_out;
    logic       last;
  } result_t;

  // Function codes of an input beat.
  localparam logic FUNC_CMD = 1'b0;
  localparam logic FUNC_RX  = 1'b1;

  // Register map (index = byte address / 4).
  localparam int          REG_IDX_W      = 1;
  localparam int          PADDR_W        = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_POLL_LIMIT = 1'b0;

  localparam logic [7:0] POLL_LIMIT_RST = 8'd9;
  localparam logic [7:0] BYTE_IDLE      = 8'hFF;
  localparam logic [7:0] START_BITS     = 8'h40;
  localparam logic [6:0] CRC7_POLY      = 7'h09;

  // Beat positions within a command frame.
  localparam logic [2:0] BEAT_START = 3'd0;
  localparam logic [2:0] BEAT_ARG3  = 3'd1;
  localparam logic [2:0] BEAT_ARG2  = 3'd2;
  localparam logic [2:0] BEAT_ARG1  = 3'd3;
  localparam logic [2:0] BEAT_ARG0  = 3'd4;
  localparam logic [2:0] BEAT_CRC   = 3'd5;
  localparam logic [2:0] BEAT_POLL  = 3'd6;

  // Advances the CRC7 (x^7 + x^3 + 1) over one byte, msb first.
  function automatic logic [6:0] crc7_byte(logic [6:0] crc, logic [7:0] data);
    logic [6:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = data[i] ^ c[6];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ CRC7_POLY;
      end
    end
    return c;
  endfunction

endpackage

### sv/sd_spi_command_issue_core.sv
// SD card SPI-mode command issuer, top level: command framing with CRC7 and R1 polling.
// Depends on sdci_pkg, sdci_cfg, sdci_in_reg, sdci_seq and sdci_out_reg.
//
// Usage. The input channel carries one beat per command (func 0: cmd_index and argument)
// or per byte received during a poll exchange (func 1: rx_byte). A command yields seven
// output beats: the start byte, four argument bytes most significant first, the CRC7
// byte, and one 0xFF poll byte marked last. Each received byte while polling yields one
// beat: the R1 response with done_res set, a timeout with response 0xFF once the poll
// limit is used up, or another 0xFF poll byte. A received byte while idle is dropped.
// A new command abandons any pending poll.
// An accepted beat is captured in the input register, and its results pass from the
// sequencer into the output register. The sequencer emits one result per cycle while
// the output register is free, so a command occupies it for seven results and a poll
// beat for one. A new beat enters the input register in the cycle the old one retires.
// When the receiver stalls, the output register holds its beat, the sequencer pauses and
// in_stall_o rises once the input register is occupied. Reset empties both registers,
// leaves polling off and sets the poll limit to 9. The poll limit is written through the
// APB port at byte address 0; a limit of 0 acts as 1.
`timescale 1ns / 1ps

module sd_spi_command_issue_core
  import sdci_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [5:0]         cmd_index_i,
  input  logic [31:0]        argument_i,
  input  logic [7:0]         rx_byte_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         tx_byte_o,
  output logic               tx_valid_o,
  output logic               done_res_o,
  output logic [7:0]         response_o,
  output logic               timed_out_o,
  output logic               last_o
);

  logic       [7:0] poll_limit;
  item_t            in_item;
  item_t            held_item;
  logic             held_valid;
  logic             take;
  logic             out_free;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  // Register file; only the poll limit lives here.
  sdci_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .poll_limit_o (poll_limit)
  );

  assign in_item.func      = func_i;
  assign in_item.cmd_index = cmd_index_i;
  assign in_item.argument  = argument_i;
  assign in_item.rx_byte   = rx_byte_i;

  // The input register keeps a command for all seven of its beats.
  sdci_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .item_i  (in_item),
    .take_i  (take),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  // The sequencer emits one result per free output cycle and owns the polling state.
  sdci_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (held_valid),
    .item_i       (held_item),
    .take_o       (take),
    .poll_limit_i (poll_limit),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  sdci_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (out_res)
  );

  assign tx_byte_o   = out_res.tx_byte;
  assign tx_valid_o  = out_res.tx_valid;
  assign done_res_o  = out_res.done_res;
  assign response_o  = out_res.response;
  assign timed_out_o = out_res.timed_out;
  assign last_o      = out_res.last;

endmodule

### sv/sdci_cfg.sv
// APB-style register file holding the poll limit of the SD SPI command issuer.
// Depends on sdci_pkg for the register map and reset value.
`timescale 1ns / 1ps

module sdci_cfg
  import sdci_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [7:0]         poll_limit_o
);

  logic [7:0]           poll_limit_q;
  logic [7:0]           poll_limit_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    poll_limit_d = poll_limit_q;
    if (wr_en && (reg_idx == REG_POLL_LIMIT)) begin
      poll_limit_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= POLL_LIMIT_RST;
    end else begin
      poll_limit_q <= poll_limit_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_POLL_LIMIT) begin
      prdata = {24'd0, poll_limit_q};
    end
  end

  assign poll_limit_o = poll_limit_q;

endmodule

### sv/sdci_in_reg.sv
// Input holding register: captures one input beat and keeps it until the sequencer retires it.
// Depends on sdci_pkg for the item type.
`timescale 1ns / 1ps

module sdci_in_reg
  import sdci_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  item_t item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  accept;

  assign stall_o = valid_q && !take_i;
  assign accept  = valid_i && !stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  // A held beat that is not retired stays held.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !take_i) |=> valid_q)
    else $error("held input beat dropped without being retired");

endmodule

### sv/sdci_seq.sv
// Beat sequencer: walks a command through its seven frame beats, runs the CRC7 one byte
// per beat and keeps the polling state. Depends on sdci_pkg.
`timescale 1ns / 1ps

module sdci_seq
  import sdci_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       take_o,
  input  logic [7:0] poll_limit_i,
  input  logic       out_free_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [2:0] beat_q, beat_d;
  logic [6:0] crc_q, crc_d;
  logic       polling_q, polling_d;
  logic [7:0] polls_left_q, polls_left_d;

  logic       is_cmd;
  logic       fire;
  logic [6:0] crc_cur;
  logic [7:0] frame_byte;
  result_t    res;

  assign is_cmd  = (item_i.func == FUNC_CMD);
  assign crc_cur = (beat_q == BEAT_START) ? 7'd0 : crc_q;

  always_comb begin
    case (beat_q)
      BEAT_START: frame_byte = START_BITS | {2'b00, item_i.cmd_index};
      BEAT_ARG3:  frame_byte = item_i.argument[31:24];
      BEAT_ARG2:  frame_byte = item_i.argument[23:16];
      BEAT_ARG1:  frame_byte = item_i.argument[15:8];
      BEAT_ARG0:  frame_byte = item_i.argument[7:0];
      BEAT_CRC:   frame_byte = {crc_q, 1'b1};
      default:    frame_byte = BYTE_IDLE;
    endcase
  end

  always_comb begin
    res = '0;
    if (is_cmd) begin
      res.tx_byte  = frame_byte;
      res.tx_valid = 1'b1;
      res.last     = (beat_q == BEAT_POLL);
    end else begin
      res.last = 1'b1;
      if (item_i.rx_byte != BYTE_IDLE) begin
        res.done_res = 1'b1;
        res.response = item_i.rx_byte;
      end else if (polls_left_q <= 8'd1) begin
        res.done_res  = 1'b1;
        res.response  = BYTE_IDLE;
        res.timed_out = 1'b1;
      end else begin
        res.tx_byte  = BYTE_IDLE;
        res.tx_valid = 1'b1;
      end
    end
  end

  // A received byte while idle is retired without a result.
  assign res_valid_o = item_valid_i && (is_cmd || polling_q);
  assign fire        = res_valid_o && out_free_i;
  assign take_o      = item_valid_i &&
                       (is_cmd ? (fire && (beat_q == BEAT_POLL)) : (!polling_q || out_free_i));
  assign res_o       = res;

  always_comb begin
    beat_d       = beat_q;
    crc_d        = crc_q;
    polling_d    = polling_q;
    polls_left_d = polls_left_q;
    if (fire) begin
      if (is_cmd) begin
        if (beat_q == BEAT_POLL) begin
          beat_d       = BEAT_START;
          polling_d    = 1'b1;
          polls_left_d = (poll_limit_i == 8'd0) ? 8'd1 : poll_limit_i;
        end else begin
          beat_d = beat_q + 3'd1;
          crc_d  = crc7_byte(crc_cur, frame_byte);
        end
      end else if (res.tx_valid) begin
        polls_left_d = polls_left_q - 8'd1;
      end else begin
        polling_d    = 1'b0;
        polls_left_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q       <= BEAT_START;
      polling_q    <= 1'b0;
      polls_left_q <= 8'd0;
    end else begin
      beat_q       <= beat_d;
      polling_q    <= polling_d;
      polls_left_q <= polls_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  // Mid-frame, the command that owns the frame is still held in the input register.
  a_frame_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_q != BEAT_START) |-> (item_valid_i && (item_i.func == FUNC_CMD)))
    else $error("frame in progress without its command beat");

  a_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q <= BEAT_POLL)
    else $error("beat counter past the poll beat");

  a_poll_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    polling_q == (polls_left_q != 8'd0))
    else $error("polling flag and remaining poll count disagree");

  a_cmd_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && is_cmd) |-> (fire && res.last))
    else $error("command retired without its last beat");

endmodule

### sv/sdci_out_reg.sv
// Result register between the sequencer and the output channel.
// Depends on sdci_pkg for the result type.
`timescale 1ns / 1ps

module sdci_out_reg
  import sdci_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign free_o = !valid_q || !stall_i;
  assign load   = free_o && valid_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### tb/sv/sd_spi_command_issue_core_test.sv
// Self-checking testbench for sd_spi_command_issue_core: CRC7 command framing and R1 polling.
// Depends on sdci_pkg and the RTL of the block; a local predictor computes most result beats.
`timescale 1ns / 1ps

module sd_spi_command_issue_core_test;
  import sdci_pkg::*;

  // Cycles the watchdog tolerates without a single accepted beat on either channel.
  localparam int WATCHDOG_LIMIT = 3000;
  // Extra cycles allowed after the last expected beat, so that a received byte
  // dropped while idle has surely left the input register.
  localparam int DRAIN_CYCLES   = 8;
  // Counted input beats per random phase.
  localparam int PHASE_ITEMS    = 25;

  // How the expected results of one stimulus beat are obtained. Most beats are
  // predicted; a few directed ones carry a value that is known by heart.
  typedef enum logic [1:0] {CHK_PRED, CHK_CRC, CHK_RESULT} chk_e;
  typedef enum logic {ROW_CFG, ROW_BEAT} row_e;
  // Shapes of one random command session.
  typedef enum logic [1:0] {SESS_ANSWER, SESS_TIMEOUT, SESS_ABANDON, SESS_NOISE} sess_e;
  // Patterns of stall on the output channel.
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  typedef struct {
    item_t      beat;
    chk_e       chk;
    logic [7:0] crc_byte;  // known CRC byte, used by CHK_CRC
    result_t    typed;     // known single result, used by CHK_RESULT
  } stim_t;

  typedef struct {
    row_e       kind;
    logic [7:0] limit;     // poll limit written by a ROW_CFG row
    stim_t      stim;
  } row_t;

  // Block ports. Every input has a known value from time zero.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               func_i      = FUNC_CMD;
  logic [5:0]         cmd_index_i = '0;
  logic [31:0]        argument_i  = '0;
  logic [7:0]         rx_byte_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         tx_byte_o;
  logic               tx_valid_o;
  logic               done_res_o;
  logic [7:0]         response_o;
  logic               timed_out_o;
  logic               last_o;

  sd_spi_command_issue_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .cmd_index_i (cmd_index_i),
    .argument_i  (argument_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_byte_o   (tx_byte_o),
    .tx_valid_o  (tx_valid_o),
    .done_res_o  (done_res_o),
    .response_o  (response_o),
    .timed_out_o (timed_out_o),
    .last_o      (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Beats waiting to be driven, and result beats the block still owes us.
  stim_t      send_q[$];
  result_t    out_beats_due[$];
  row_t       dir_rows[$];

  // Shadow of the block's configuration and polling state.
  logic [7:0] lim_shadow      = POLL_LIMIT_RST;
  logic       poll_active     = 1'b0;
  logic [7:0] polls_remaining = '0;

  // Sender and receiver pacing.
  stim_t      cur_stim;
  int         burst_left = 1;
  int         gap_left   = 0;
  rx_mode_e   stall_mode = RX_FREE;
  int         stall_span = 0;
  int         stall_tick = 0;

  result_t    due_beat;
  result_t    seen_beat;
  int         idle_cycles = 0;
  int         errors      = 0;
  int         n_cmds      = 0;
  int         n_polls     = 0;
  int         n_ignored   = 0;
  int         n_out       = 0;
  int         n_resp      = 0;
  int         n_tmo       = 0;

  function automatic result_t mk_res(logic [7:0] tx, logic txv, logic done, logic [7:0] resp,
                                     logic to, logic fin);
    result_t r;
    r.tx_byte   = tx;
    r.tx_valid  = txv;
    r.done_res  = done;
    r.response  = resp;
    r.timed_out = to;
    r.last      = fin;
    return r;
  endfunction

  function automatic stim_t mk_stim(logic func, logic [5:0] cmd, logic [31:0] arg,
                                    logic [7:0] rx);
    stim_t s;
    s.beat.func      = func;
    s.beat.cmd_index = cmd;
    s.beat.argument  = arg;
    s.beat.rx_byte   = rx;
    s.chk            = CHK_PRED;
    s.crc_byte       = '0;
    s.typed          = '0;
    return s;
  endfunction

  // CRC7 (x^7 + x^3 + 1) over the five leading frame bytes, taken as one 40-bit
  // word and walked msb first.
  function automatic logic [6:0] frame_crc7(logic [39:0] frame);
    logic [6:0] acc;
    logic       fb;
    acc = '0;
    for (int b = 39; b >= 0; b--) begin
      fb  = frame[b] ^ acc[6];
      acc = {acc[5:0], 1'b0} ^ (fb ? CRC7_POLY : 7'h00);
    end
    return acc;
  endfunction

  // Works out the result beats one accepted input beat causes and queues them.
  // A command always yields the six frame bytes and one poll byte; a received
  // byte while polling yields exactly one beat; a received byte while idle is
  // dropped and leaves the state alone.
  task automatic issue_step(input stim_t s);
    logic [39:0] frame;
    logic [7:0]  crc_byte;
    result_t     beat;
    if (s.beat.func == FUNC_CMD) begin
      frame    = {START_BITS | {2'b00, s.beat.cmd_index}, s.beat.argument};
      crc_byte = {frame_crc7(frame), 1'b1};
      if (s.chk == CHK_CRC) begin
        crc_byte = s.crc_byte;
      end
      for (int k = 4; k >= 0; k--) begin
        out_beats_due.push_back(mk_res(frame[8*k +: 8], 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
      end
      out_beats_due.push_back(mk_res(crc_byte, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
      out_beats_due.push_back(mk_res(BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1));
      // A new command abandons any poll in flight. A limit of zero acts as one.
      poll_active     = 1'b1;
      polls_remaining = (lim_shadow == 8'd0) ? 8'd1 : lim_shadow;
      n_cmds++;
    end else if (!poll_active) begin
      n_ignored++;
    end else begin
      if (s.beat.rx_byte != BYTE_IDLE) begin
        beat            = mk_res(8'h00, 1'b0, 1'b1, s.beat.rx_byte, 1'b0, 1'b1);
        poll_active     = 1'b0;
        polls_remaining = '0;
      end else if (polls_remaining <= 8'd1) begin
        beat            = mk_res(8'h00, 1'b0, 1'b1, BYTE_IDLE, 1'b1, 1'b1);
        poll_active     = 1'b0;
        polls_remaining = '0;
      end else begin
        beat            = mk_res(BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);
        polls_remaining = polls_remaining - 8'd1;
      end
      if (s.chk == CHK_RESULT) begin
        beat = s.typed;
      end
      out_beats_due.push_back(beat);
      n_polls++;
    end
  endtask

  // Sender. It works in bursts of random length separated by random gaps, and
  // only moves on once the current beat has been taken, so a stalled beat is
  // held unchanged. Valid is decided without looking at the stall.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        issue_step(cur_stim);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (send_q.size() > 0) begin
          cur_stim = send_q.pop_front();
          func_i      <= cur_stim.beat.func;
          cmd_index_i <= cur_stim.beat.cmd_index;
          argument_i  <= cur_stim.beat.argument;
          rx_byte_i   <= cur_stim.beat.rx_byte;
          in_valid_i  <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            // Some bursts follow each other back to back.
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver. The stall pattern switches after random spans between none,
  // light random, heavy random and a fixed periodic pattern.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = rx_mode_e'($urandom_range(0, 3));
        stall_span = $urandom_range(20, 80);
      end else begin
        stall_span--;
      end
      case (stall_mode)
        RX_FREE: begin
          out_stall_i <= 1'b0;
        end
        RX_LIGHT: begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
        end
        RX_HEAVY: begin
          out_stall_i <= ($urandom_range(0, 9) < 6);
        end
        default: begin
          out_stall_i <= (stall_tick % 3 == 0);
        end
      endcase
      stall_tick++;
    end
  end

  function automatic int field_bad(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Checker. Every accepted result beat is compared field by field with the
  // oldest beat still owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_beat = mk_res(tx_byte_o, tx_valid_o, done_res_o, response_o, timed_out_o, last_o);
      n_out++;
      if (seen_beat.done_res && seen_beat.timed_out) begin
        n_tmo++;
      end else if (seen_beat.done_res) begin
        n_resp++;
      end
      if (out_beats_due.size() == 0) begin
        $error("result beat with nothing expected: tx_byte 0x%0h done_res %0b",
               tx_byte_o, done_res_o);
        errors++;
      end else begin
        due_beat = out_beats_due.pop_front();
        errors += field_bad("tx_byte", 32'(due_beat.tx_byte), 32'(seen_beat.tx_byte));
        errors += field_bad("tx_valid", 32'(due_beat.tx_valid), 32'(seen_beat.tx_valid));
        errors += field_bad("done_res", 32'(due_beat.done_res), 32'(seen_beat.done_res));
        errors += field_bad("response", 32'(due_beat.response), 32'(seen_beat.response));
        errors += field_bad("timed_out", 32'(due_beat.timed_out),
                            32'(seen_beat.timed_out));
        errors += field_bad("last", 32'(due_beat.last), 32'(seen_beat.last));
      end
    end
  end

  // Watchdog: a correct block never goes this long without moving a beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Writes the poll limit over APB, then reads it back.
  task automatic cfg_write(input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_POLL_LIMIT, 2'b00};
    pwdata  <= {24'h000000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    lim_shadow = value;
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    errors += field_bad("poll_limit", 32'(value), 32'(prdata[7:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Returns once every queued beat is taken and every owed result has come,
  // then waits DRAIN_CYCLES for a dropped byte left in the block. The queues
  // and the valid are looked at on the falling edge, once the sender has
  // settled for the cycle.
  task automatic wait_drained;
    while (send_q.size() != 0 || in_valid_i || out_beats_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic stim_t rand_cmd_stim();
    logic [31:0] arg;
    case ($urandom_range(0, 7))
      0:       arg = 32'h00000000;
      1:       arg = 32'hFFFFFFFF;
      default: arg = $urandom;
    endcase
    return mk_stim(FUNC_CMD, 6'($urandom_range(0, 63)), arg, 8'($urandom_range(0, 255)));
  endfunction

  // The command fields of a received-byte beat are noise the block must ignore.
  function automatic stim_t rand_rx_stim(logic [7:0] rx);
    return mk_stim(FUNC_RX, 6'($urandom_range(0, 63)), $urandom, rx);
  endfunction

  // Queues one command session: a command, some 0xFF polls, and then a
  // response, a timeout, nothing (the next command abandons it) or a response
  // followed by stray bytes that arrive while idle.
  task automatic queue_session(input int eff, inout int counted);
    int    r;
    int    n;
    sess_e shape;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      shape = SESS_ANSWER;
    end else if (r < 8) begin
      shape = (eff <= 16) ? SESS_TIMEOUT : SESS_ANSWER;
    end else if (r < 9) begin
      shape = SESS_ABANDON;
    end else begin
      shape = SESS_NOISE;
    end
    send_q.push_back(rand_cmd_stim());
    counted++;
    n = (shape == SESS_TIMEOUT) ? eff : $urandom_range(0, (eff - 1 < 12) ? eff - 1 : 12);
    if (shape == SESS_NOISE) begin
      n = 0;
    end
    repeat (n) begin
      send_q.push_back(rand_rx_stim(BYTE_IDLE));
      counted++;
    end
    if (shape == SESS_ANSWER || shape == SESS_NOISE) begin
      send_q.push_back(rand_rx_stim(8'($urandom_range(0, 254))));
      counted++;
    end
    if (shape == SESS_NOISE) begin
      repeat ($urandom_range(1, 3)) begin
        send_q.push_back(rand_rx_stim(8'($urandom_range(0, 255))));
      end
    end
  endtask

  task automatic row_beat(input stim_t s, input chk_e chk, input logic [7:0] crc,
                          input result_t typed);
    row_t row;
    row.kind       = ROW_BEAT;
    row.limit      = '0;
    row.stim       = s;
    row.stim.chk   = chk;
    row.stim.crc_byte = crc;
    row.stim.typed = typed;
    dir_rows.push_back(row);
  endtask

  task automatic row_cfg(input logic [7:0] limit);
    row_t row;
    row.kind  = ROW_CFG;
    row.limit = limit;
    row.stim  = mk_stim(FUNC_CMD, '0, '0, '0);
    dir_rows.push_back(row);
  endtask

  // Main sequence: reset, a directed table, then random phases at several
  // poll limits, the extremes among them.
  initial begin
    logic [7:0] phase_lims[7];
    result_t    poll_res;
    result_t    tmo_res;
    int         eff;
    int         counted;

    poll_res = mk_res(BYTE_IDLE, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);
    tmo_res  = mk_res(8'h00, 1'b0, 1'b1, BYTE_IDLE, 1'b1, 1'b1);

    // Directed table. The poll limit starts at its reset value of nine.
    // A received byte while idle is dropped.
    row_beat(mk_stim(FUNC_RX, 6'd0, 32'h0, 8'h00), CHK_PRED, 8'h00, '0);
    // CMD0 with a zero argument has the well-known CRC byte 0x95.
    row_beat(mk_stim(FUNC_CMD, 6'd0, 32'h00000000, 8'hFF), CHK_CRC, 8'h95, '0);
    row_beat(mk_stim(FUNC_RX, 6'd0, 32'h0, 8'h01), CHK_RESULT, 8'h00,
             mk_res(8'h00, 1'b0, 1'b1, 8'h01, 1'b0, 1'b1));
    // CMD8 with 0x1AA has the well-known CRC byte 0x87.
    row_beat(mk_stim(FUNC_CMD, 6'd8, 32'h000001AA, 8'h00), CHK_CRC, 8'h87, '0);
    // Nine 0xFF bytes use up the poll limit: eight more polls, then a timeout.
    repeat (8) row_beat(mk_stim(FUNC_RX, 6'd63, 32'hFFFFFFFF, 8'hFF), CHK_RESULT, 8'h00,
                        poll_res);
    row_beat(mk_stim(FUNC_RX, 6'd0, 32'h0, 8'hFF), CHK_RESULT, 8'h00, tmo_res);
    row_beat(mk_stim(FUNC_RX, 6'd0, 32'h0, 8'h00), CHK_PRED, 8'h00, '0);
    // A poll limit of zero behaves as one.
    row_cfg(8'd0);
    row_beat(mk_stim(FUNC_CMD, 6'd63, 32'hFFFFFFFF, 8'h00), CHK_PRED, 8'h00, '0);
    row_beat(mk_stim(FUNC_RX, 6'd0, 32'h0, 8'hFF), CHK_RESULT, 8'h00, tmo_res);
    // Smallest real limit; a command while polling abandons the pending poll.
    row_cfg(8'd1);
    row_beat(mk_stim(FUNC_CMD, 6'd17, 32'h12345678, 8'hA5), CHK_PRED, 8'h00, '0);
    row_beat(mk_stim(FUNC_CMD, 6'd55, 32'h00000000, 8'h5A), CHK_PRED, 8'h00, '0);
    row_beat(mk_stim(FUNC_RX, 6'd0, 32'h0, 8'h00), CHK_RESULT, 8'h00,
             mk_res(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1));
    row_beat(mk_stim(FUNC_CMD, 6'd41, 32'h40000000, 8'h00), CHK_PRED, 8'h00, '0);
    row_beat(mk_stim(FUNC_RX, 6'd0, 32'h0, 8'hFE), CHK_RESULT, 8'h00,
             mk_res(8'h00, 1'b0, 1'b1, 8'hFE, 1'b0, 1'b1));
    row_beat(mk_stim(FUNC_RX, 6'd0, 32'h0, 8'hFF), CHK_PRED, 8'h00, '0);
    row_beat(mk_stim(FUNC_CMD, 6'd24, 32'hA5A5A5A5, 8'hFF), CHK_PRED, 8'h00, '0);
    row_beat(mk_stim(FUNC_RX, 6'd0, 32'h0, 8'hFF), CHK_RESULT, 8'h00, tmo_res);

    // Random phases: the largest limit, small ones, zero and random settings.
    phase_lims[0] = 8'd255;
    phase_lims[1] = 8'd2;
    phase_lims[2] = 8'($urandom_range(3, 16));
    phase_lims[3] = 8'd0;
    phase_lims[4] = 8'd1;
    phase_lims[5] = 8'($urandom_range(1, 255));
    phase_lims[6] = 8'($urandom_range(3, 16));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(dir_rows[i].limit);
      end else begin
        send_q.push_back(dir_rows[i].stim);
      end
    end

    foreach (phase_lims[p]) begin
      wait_drained();
      cfg_write(phase_lims[p]);
      eff     = (phase_lims[p] == 8'd0) ? 1 : int'(phase_lims[p]);
      counted = 0;
      while (counted < PHASE_ITEMS) queue_session(eff, counted);
    end

    wait_drained();

    $display("Covered %0d commands, %0d poll beats and %0d dropped bytes; %0d result beats.",
             n_cmds, n_polls, n_ignored, n_out);
    $display("Poll limits 9, 0, 1, 2, 255 and random; %0d responses and %0d timeouts seen.",
             n_resp, n_tmo);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
